// ===== sv/dual_processor_mailbox_fifo_unit_defines.svh =====
// Assertion macros for the dual-processor mailbox FIFO unit.
// Needs a clock aclk and an active-low reset aresetn in the including scope.
`ifndef DUAL_PROCESSOR_MAILBOX_FIFO_UNIT_DEFINES_SVH
`define DUAL_PROCESSOR_MAILBOX_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mailbox check failed");

// Next-cycle implication, checked outside reset.
`define MBX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mailbox check failed");

`endif

// ===== sv/mbx_pkg.sv =====
// Shared types and constants for the dual-processor mailbox FIFO unit.
// No dependencies.
`timescale 1ns / 1ps

package mbx_pkg;

    localparam int WORD_W = 32;

    // access kinds carried in the mode field
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_CTRL = 2'd2;

    // per-chain operation for one item; at most one bit is set
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } chain_ctrl_t;

endpackage

// ===== sv/mbx_cell.sv =====
// One storage cell of the mailbox word chain.
// Depends on mbx_pkg for the word width.
`timescale 1ns / 1ps

module mbx_cell (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      shift,
    input  logic [mbx_pkg::WORD_W-1:0] load_data,
    input  logic [mbx_pkg::WORD_W-1:0] upper_data,
    output logic [mbx_pkg::WORD_W-1:0] word
);

    logic [mbx_pkg::WORD_W-1:0] word_reg;
    logic [mbx_pkg::WORD_W-1:0] word_next;

    // load a new word, or take the neighbour's word on a pop
    always_comb begin
        priority if (load) begin
            word_next = load_data;
        end else if (shift) begin
            word_next = upper_data;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== sv/mbx_chain.sv =====
// One send FIFO built as a row of mbx_cell stages with the head at cell 0.
// Depends on mbx_pkg and mbx_cell.
`timescale 1ns / 1ps

module mbx_chain #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mbx_pkg::chain_ctrl_t               ctrl,
    input  logic [mbx_pkg::WORD_W-1:0]         push_data,
    output logic [mbx_pkg::WORD_W-1:0]         head_data,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]    count,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]    count_next
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [CW-1:0]                 count_reg;
    logic [mbx_pkg::WORD_W-1:0]    cell_word [FIFO_DEPTH];

    genvar i;
    generate
        for (i = 0; i < FIFO_DEPTH; i++) begin : g_cell
            logic [mbx_pkg::WORD_W-1:0] upper;
            if (i == FIFO_DEPTH - 1) begin : g_last
                assign upper = cell_word[i];
            end else begin : g_mid
                assign upper = cell_word[i+1];
            end
            mbx_cell u_cell (
                .aclk       (aclk),
                .load       (ctrl.push && (count_reg == CW'(i))),
                .shift      (ctrl.pop),
                .load_data  (push_data),
                .upper_data (upper),
                .word       (cell_word[i])
            );
        end
    endgenerate

    always_comb begin
        priority if (ctrl.flush) begin
            count_next = '0;
        end else if (ctrl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_data = cell_word[0];
    assign count     = count_reg;

endmodule

// ===== sv/dual_processor_mailbox_fifo_unit.sv =====
// Top level of the dual-processor mailbox: two word chains, side control, result register.
// Depends on mbx_pkg, mbx_chain, mbx_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_processor_mailbox_fifo_unit_defines.svh"

// Usage
//   Each item on the s_ channel is one access by one processor: a send into
//   its own FIFO, a receive from the other side's FIFO, or a control write.
//   Every accepted item yields exactly one result item on the m_ channel,
//   carrying the word read, the accessing side's flags and interrupt pulses.
// Latency and throughput
//   m_tvalid rises in the cycle after acceptance. One item per cycle is sustained
//   while m_tready is high: the access updates a fill count and the cell row together,
//   and the result register is refilled in the cycle it is taken.
// Reset
//   aresetn low clears both fill counts, all enables and error flags, and
//   the result register's valid bit. The cell words are not cleared; only
//   words pushed since the last flush are ever read.
// Stall
//   While m_tready is low a waiting result holds and s_tready drops, so no
//   item is lost or overwritten; with the result register empty one more
//   item is still taken.
module dual_processor_mailbox_fifo_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] data, [32] clear_error, [33] flush_send, [34] enable_in,
    // [35] send_irq_enable_in, [36] recv_irq_enable_in, [39:37] zero
    input  logic [39:0] s_tdata,
    // [1:0] mode, [2] side
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] send_empty, [33] send_full, [34] recv_empty,
    // [35] recv_full, [36] error_flag, [38:37] irq_send_empty,
    // [40:39] irq_recv_nonempty, [47:41] zero
    output logic [47:0] m_tdata
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // unpack the item
    logic [1:0]                 mode;
    logic                       side;
    logic                       oth;
    logic [mbx_pkg::WORD_W-1:0] data;
    logic                       clear_error;
    logic                       flush_send;
    logic                       enable_in;
    logic                       send_irq_enable_in;
    logic                       recv_irq_enable_in;

    assign mode               = s_tuser[1:0];
    assign side               = s_tuser[2];
    assign oth                = ~side;
    assign data               = s_tdata[31:0];
    assign clear_error        = s_tdata[32];
    assign flush_send         = s_tdata[33];
    assign enable_in          = s_tdata[34];
    assign send_irq_enable_in = s_tdata[35];
    assign recv_irq_enable_in = s_tdata[36];

    // per-side control registers
    logic [1:0] enable_reg,   enable_next;
    logic [1:0] send_ie_reg,  send_ie_next;
    logic [1:0] recv_ie_reg,  recv_ie_next;
    logic [1:0] error_reg,    error_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg,  out_data_next;

    logic                       acc;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       ctrl_wr;
    logic                       own_full;
    logic                       oth_empty;
    mbx_pkg::chain_ctrl_t       ctrl [2];
    logic [mbx_pkg::WORD_W-1:0] head [2];
    logic [CW-1:0]              cnt [2];
    logic [CW-1:0]              cnt_next [2];
    logic [mbx_pkg::WORD_W-1:0] rd_word;
    logic [1:0]                 irq_se;
    logic [1:0]                 irq_rn;

    // take a new item whenever the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;

    assign own_full  = (cnt[side] == CW'(FIFO_DEPTH));
    assign oth_empty = (cnt[oth] == '0);
    assign push_ok   = acc && (mode == mbx_pkg::MODE_SEND) && enable_reg[side] && !own_full;
    assign pop_ok    = acc && (mode == mbx_pkg::MODE_RECV) && enable_reg[side] && !oth_empty;
    assign ctrl_wr   = acc && (mode == mbx_pkg::MODE_CTRL);

    genvar x;
    generate
        for (x = 0; x < 2; x++) begin : g_side
            always_comb begin
                ctrl[x].push  = push_ok && (side == 1'(x));
                ctrl[x].pop   = pop_ok && (oth == 1'(x));
                ctrl[x].flush = ctrl_wr && flush_send && (side == 1'(x));
            end
            mbx_chain #(
                .FIFO_DEPTH (FIFO_DEPTH)
            ) u_chain (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl[x]),
                .push_data  (data),
                .head_data  (head[x]),
                .count      (cnt[x]),
                .count_next (cnt_next[x])
            );
        end
    endgenerate

    // side control: set error on a failed access, load enables and clear error on a control write
    always_comb begin
        enable_next  = enable_reg;
        send_ie_next = send_ie_reg;
        recv_ie_next = recv_ie_reg;
        error_next   = error_reg;
        if (acc) begin
            if (mode == mbx_pkg::MODE_SEND) begin
                if (enable_reg[side] && own_full) begin
                    error_next[side] = 1'b1;
                end
            end else if (mode == mbx_pkg::MODE_RECV) begin
                if (enable_reg[side] && oth_empty) begin
                    error_next[side] = 1'b1;
                end
            end else if (mode == mbx_pkg::MODE_CTRL) begin
                if (clear_error) begin
                    error_next[side] = 1'b0;
                end
                enable_next[side]  = enable_in;
                send_ie_next[side] = send_irq_enable_in;
                recv_ie_next[side] = recv_irq_enable_in;
            end
        end
    end

    // interrupt pulses for this item
    always_comb begin
        irq_se = '0;
        irq_rn = '0;
        if (push_ok && recv_ie_reg[oth]) begin
            irq_rn[oth] = 1'b1;
        end
        if (pop_ok && (cnt_next[oth] == '0) && send_ie_reg[oth]) begin
            irq_se[oth] = 1'b1;
        end
        if (ctrl_wr) begin
            irq_se[side] = send_irq_enable_in && (cnt_next[side] == '0);
            irq_rn[side] = recv_irq_enable_in && !oth_empty;
        end
    end

    assign rd_word = pop_ok ? head[oth] : '0;

    // hold the result while stalled, load it when an item is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (acc) begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0,
                              irq_rn,
                              irq_se,
                              error_next[side],
                              (cnt_next[oth] == CW'(FIFO_DEPTH)),
                              (cnt_next[oth] == '0),
                              (cnt_next[side] == CW'(FIFO_DEPTH)),
                              (cnt_next[side] == '0),
                              rd_word};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= '0;
            send_ie_reg   <= '0;
            recv_ie_reg   <= '0;
            error_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            enable_reg    <= enable_next;
            send_ie_reg   <= send_ie_next;
            recv_ie_reg   <= recv_ie_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a successful send into side 0 advances its fill count by one
    `MBX_ASSERT_NXT(a_push_count, push_ok && !side, cnt[0] == $past(cnt[0]) + CW'(1))
    // a result without a successful pop reads zero
    `MBX_ASSERT_NXT(a_read_zero, acc && !pop_ok, m_tdata[31:0] == '0)
    // an error flag only rises as the result of an accepted item
    `MBX_ASSERT_IMP(a_error_cause, $rose(error_reg[0]) || $rose(error_reg[1]), $past(acc))

endmodule
